[hw/rtl/ptt_pkg.sv]
// shared constants, field widths and arithmetic helpers for the pid tilt/thrust block
// no dependencies
`default_nettype none
package ptt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int INTEG_BITS = 48;
   localparam int DT_WIDTH   = 17;
   localparam int GAIN_WIDTH = 31;
   localparam int TILT_WIDTH = 18;
   localparam int CORDIC_STAGES = 31;
   localparam int ANGLE_FRAC = 30;

   localparam int REQ_WIDTH = 312;
   localparam int RSP_WIDTH = 104;

   // register indexes
   localparam logic [2:0] REG_KP_H    = 3'd0;
   localparam logic [2:0] REG_KD_H    = 3'd1;
   localparam logic [2:0] REG_KI_H    = 3'd2;
   localparam logic [2:0] REG_KP_V    = 3'd3;
   localparam logic [2:0] REG_KD_V    = 3'd4;
   localparam logic [2:0] REG_KI_V    = 3'd5;
   localparam logic [2:0] REG_GRAVITY = 3'd6;
   localparam logic [2:0] REG_MASS    = 3'd7;

   localparam logic [30:0] GRAVITY_RESET = 31'd642908;
   localparam logic [30:0] MASS_RESET    = 31'd65536;

   // atan(2^-i) in Q30
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // signed value from sign and magnitude, clamped to 32 bits
   function automatic logic signed [31:0] sat_mag32(input logic neg, input logic [63:0] m);
      logic signed [31:0] r;
      if (neg) begin
         if (m > 64'h8000_0000) r = 32'sh8000_0000;
         else r = 32'(64'd0 - m);
      end else begin
         if (m > 64'h7fff_ffff) r = 32'sh7fff_ffff;
         else r = m[31:0];
      end
      return r;
   endfunction

   // same, clamped to 48 bits
   function automatic logic signed [47:0] sat_mag48(input logic neg, input logic [63:0] m);
      logic signed [47:0] r;
      if (neg) begin
         if (m > 64'h8000_0000_0000) r = 48'sh8000_0000_0000;
         else r = 48'(64'd0 - m);
      end else begin
         if (m > 64'h7fff_ffff_ffff) r = 48'sh7fff_ffff_ffff;
         else r = m[47:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat34_to32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = 32'sh7fff_ffff;
      else if (v < -34'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [47:0] sat49_to48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v > 49'sh0_7fff_ffff_ffff) r = 48'sh7fff_ffff_ffff;
      else if (v < -49'sh0_8000_0000_0000) r = 48'sh8000_0000_0000;
      else r = v[47:0];
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/ptt_mulq.sv]
// fixed-point multiply unit: 48 x 31 magnitude product in two 32-bit passes,
// shift by the fraction bits and clamp; uses ptt_pkg
`default_nettype none
module ptt_mulq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               neg,
   input  wire logic [47:0]        a_mag,
   input  wire logic [30:0]        b,
   input  wire logic               wide,
   output logic                    done,
   output logic signed [47:0]      result
);
   logic [2:0]  phase_ff, phase_in;
   logic [47:0] a_ff, a_in;
   logic [30:0] b_ff, b_in;
   logic        neg_ff, neg_in, wide_ff, wide_in;
   logic [62:0] prod_ff, prod_in;
   logic [78:0] acc_ff, acc_in;
   logic signed [47:0] result_ff, result_in;
   logic [31:0] mul_op;
   logic [63:0] shifted;

   assign mul_op  = (phase_ff == 3'd1) ? a_ff[31:0] : {16'd0, a_ff[47:32]};
   assign shifted = {1'b0, acc_ff[78:ptt_pkg::FRAC_BITS]};

   always_comb begin
      phase_in  = phase_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      wide_in   = wide_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      case (phase_ff)
         3'd0: begin
            if (start) begin
               a_in = a_mag; b_in = b; neg_in = neg; wide_in = wide; phase_in = 3'd1;
            end
         end
         3'd1: begin
            prod_in  = 63'(mul_op * b_ff);
            phase_in = 3'd2;
         end
         3'd2: begin
            acc_in   = {16'd0, prod_ff};
            prod_in  = 63'(mul_op * b_ff);
            phase_in = 3'd3;
         end
         3'd3: begin
            acc_in   = acc_ff + {prod_ff[46:0], 32'd0};
            phase_in = 3'd4;
         end
         3'd4: begin
            if (wide_ff) result_in = ptt_pkg::sat_mag48(neg_ff, shifted);
            else result_in = 48'(ptt_pkg::sat_mag32(neg_ff, shifted));
            phase_in = 3'd5;
         end
         default: phase_in = 3'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= 3'd0;
      else phase_ff <= phase_in;
      a_ff <= a_in; b_ff <= b_in; neg_ff <= neg_in; wide_ff <= wide_in;
      prod_ff <= prod_in; acc_ff <= acc_in; result_ff <= result_in;
   end

   assign done   = (phase_ff == 3'd5);
   assign result = result_ff;
endmodule
`default_nettype wire

[hw/rtl/ptt_div.sv]
// restoring divider, one quotient bit per cycle: (mag << frac) / time step,
// clamped to 32 bits; uses ptt_pkg
`default_nettype none
module ptt_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               neg,
   input  wire logic [32:0]        num_mag,
   input  wire logic [16:0]        den,
   output logic                    done,
   output logic signed [31:0]      result
);
   localparam int NUM_BITS = 33 + ptt_pkg::FRAC_BITS;

   logic [5:0]            count_ff, count_in;
   logic                  busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [NUM_BITS-1:0]   num_ff, num_in, quo_ff, quo_in;
   logic [16:0]           rem_ff, rem_in, den_ff, den_in;
   logic [17:0]           trial;
   logic signed [31:0]    result_ff, result_in;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};

   always_comb begin
      count_in = count_ff; busy_in = busy_ff; done_in = 1'b0; neg_in = neg_ff;
      num_in = num_ff; quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      result_in = result_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         neg_in   = neg;
         num_in   = {num_mag, {ptt_pkg::FRAC_BITS{1'b0}}};
         den_in   = den;
         rem_in   = '0;
         quo_in   = '0;
         count_in = 6'(NUM_BITS);
      end else if (busy_ff) begin
         if (count_ff != 6'd0) begin
            num_in = {num_ff[NUM_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 17'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[16:0];
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            count_in = count_ff - 6'd1;
         end else begin
            result_in = ptt_pkg::sat_mag32(neg_ff, 64'(quo_ff));
            busy_in   = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; count_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; count_ff <= count_in;
      end
      neg_ff <= neg_in; num_ff <= num_in; quo_ff <= quo_in; rem_ff <= rem_in;
      den_ff <= den_in; result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire

[hw/rtl/ptt_cordic.sv]
// vectoring cordic for atan2(acc, g): bit-at-a-time normalize, 31 rotations,
// round to output fraction; uses ptt_pkg
`default_nettype none
module ptt_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] acc,
   input  wire logic [30:0]        grav,
   output logic                    done,
   output logic signed [17:0]      tilt
);
   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_NORM = 2'd1;
   localparam logic [1:0] C_ITER = 2'd2;
   localparam logic [1:0] C_ROUND = 2'd3;
   localparam int RSH = ptt_pkg::ANGLE_FRAC - ptt_pkg::FRAC_BITS;

   logic [1:0]         state_ff, state_in;
   logic               done_ff, done_in, neg_ff, neg_in;
   logic [4:0]         step_ff, step_in;
   logic [52:0]        mx_ff, mx_in;
   logic signed [56:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [32:0] z_ff, z_in;
   logic signed [17:0] tilt_ff, tilt_in;
   logic [32:0]        acc_mag, z_mag, z_rnd;
   logic [31:0]        amag;

   assign acc_mag = acc[31] ? 33'(-{acc[31], acc}) : {1'b0, acc};
   assign amag    = acc_mag[31:0];
   assign xs      = x_ff >>> step_ff;
   assign ys      = y_ff >>> step_ff;
   assign z_mag   = z_ff[32] ? 33'(-z_ff) : z_ff;
   assign z_rnd   = (z_mag + 33'(1 << (RSH - 1))) >> RSH;

   always_comb begin
      state_in = state_ff; done_in = 1'b0; neg_in = neg_ff; step_in = step_ff;
      mx_in = mx_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; tilt_in = tilt_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               neg_in = acc[31];
               x_in   = 57'(grav);
               y_in   = 57'(amag);
               mx_in  = (amag > {1'b0, grav}) ? 53'(amag) : 53'(grav);
               z_in   = '0;
               state_in = C_NORM;
            end
         end
         C_NORM: begin
            if (!mx_ff[52]) begin
               mx_in = {mx_ff[51:0], 1'b0};
               x_in  = x_ff <<< 1;
               y_in  = y_ff <<< 1;
            end else begin
               if (neg_ff) y_in = -y_ff;
               step_in  = '0;
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!y_ff[56]) begin
               x_in = x_ff + ys; y_in = y_ff - xs;
               z_in = z_ff + 33'(ptt_pkg::atan_entry(step_ff));
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs;
               z_in = z_ff - 33'(ptt_pkg::atan_entry(step_ff));
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ptt_pkg::CORDIC_STAGES - 1)) state_in = C_ROUND;
         end
         C_ROUND: begin
            tilt_in  = z_ff[32] ? 18'(-z_rnd) : z_rnd[17:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE; done_ff <= 1'b0;
      end else begin
         state_ff <= state_in; done_ff <= done_in;
      end
      neg_ff <= neg_in; step_ff <= step_in; mx_ff <= mx_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; tilt_ff <= tilt_in;
   end

   assign done = done_ff;
   assign tilt = tilt_ff;
endmodule
`default_nettype wire

[hw/rtl/pid_position_to_tilt_thrust.sv]
// top level of the three-axis pid position controller with tilt/thrust output
// uses ptt_pkg, ptt_mulq, ptt_div, ptt_cordic
`default_nettype none
// One item is one control tick. The block takes it only when idle and works it through
// a small sequencer that drives one shared multiplier (two 32-bit passes per product),
// a one-bit-per-cycle divider and one cordic unit. Per axis: the error, the derivative
// division, the integral increment and the three gain products, then the sum is closed.
// Each tilt then takes a start, a normalize, 31 rotations and a round and hand-back,
// and thrust one more product. The sequencer returns to idle before the next item is
// taken. The finished result sits in an output register, so the next item can be taken
// while it waits.
module pid_position_to_tilt_thrust (
   input  wire logic         clock,
   input  wire logic         reset,
   // ref_x, ref_y, ref_z, meas_x, meas_y, meas_z, ff_acc_x, ff_acc_y, ff_acc_z,
   // time_step (17 bits), zero fill
   input  wire logic [311:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tilt_x (18), tilt_y (18), vertical_acc (32), thrust_force (32), zero fill
   output logic [103:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [30:0]  csr_data
);
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_ERR  = 5'd1;
   localparam logic [4:0] S_DIV_GO = 5'd2;
   localparam logic [4:0] S_DIV_W  = 5'd3;
   localparam logic [4:0] S_INC_GO = 5'd4;
   localparam logic [4:0] S_INC_W  = 5'd5;
   localparam logic [4:0] S_KP_GO  = 5'd6;
   localparam logic [4:0] S_KP_W   = 5'd7;
   localparam logic [4:0] S_KD_GO  = 5'd8;
   localparam logic [4:0] S_KD_W   = 5'd9;
   localparam logic [4:0] S_KI_GO  = 5'd10;
   localparam logic [4:0] S_KI_W   = 5'd11;
   localparam logic [4:0] S_SUM    = 5'd12;
   localparam logic [4:0] S_TX_GO  = 5'd13;
   localparam logic [4:0] S_TX_W   = 5'd14;
   localparam logic [4:0] S_TY_GO  = 5'd15;
   localparam logic [4:0] S_TY_W   = 5'd16;
   localparam logic [4:0] S_TH_GO  = 5'd17;
   localparam logic [4:0] S_TH_W   = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   logic [4:0]   state_ff, state_in;
   logic [1:0]   axis_ff, axis_in;
   logic [311:0] item_ff, item_in;

   // configuration registers
   logic [30:0]  gain_ff [8];

   // controller state
   logic signed [31:0] prev_ff [3];
   logic signed [47:0] integ_ff [3];

   logic signed [31:0] err_ff, err_in, der_ff, der_in;
   logic signed [33:0] sum_ff, sum_in;
   logic signed [31:0] acc_ff [3];
   logic signed [17:0] tilt_x_ff, tilt_x_in, tilt_y_ff, tilt_y_in;
   logic signed [31:0] thrust_ff, thrust_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [103:0]       rsp_data_ff, rsp_data_in;

   // per-axis operand selection
   logic signed [31:0] ref_sel, meas_sel, ff_sel, prev_sel;
   logic signed [47:0] integ_sel;
   logic [30:0]        kp_sel, kd_sel, ki_sel, grav_eff;
   logic [16:0]        dt_eff;
   logic signed [32:0] pos_diff, err_diff, thrust_base;
   logic [32:0]        diff_mag;
   logic [31:0]        err_mag, der_mag, thr_mag;
   logic [47:0]        integ_mag;
   logic signed [48:0] integ_sum;

   logic               mul_start, mul_neg, mul_wide, mul_done;
   logic [47:0]        mul_a;
   logic [30:0]        mul_b;
   logic signed [47:0] mul_res;
   logic               div_start, div_done;
   logic signed [31:0] div_res;
   logic               cor_start, cor_done;
   logic signed [31:0] cor_acc;
   logic signed [17:0] cor_tilt;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // three-entry selects by axis
   assign ref_sel   = item_ff[32*axis_ff +: 32];
   assign meas_sel  = item_ff[96 + 32*axis_ff +: 32];
   assign ff_sel    = item_ff[192 + 32*axis_ff +: 32];
   assign prev_sel  = prev_ff[axis_ff];
   assign integ_sel = integ_ff[axis_ff];
   assign kp_sel    = (axis_ff == 2'd2) ? gain_ff[ptt_pkg::REG_KP_V] : gain_ff[ptt_pkg::REG_KP_H];
   assign kd_sel    = (axis_ff == 2'd2) ? gain_ff[ptt_pkg::REG_KD_V] : gain_ff[ptt_pkg::REG_KD_H];
   assign ki_sel    = (axis_ff == 2'd2) ? gain_ff[ptt_pkg::REG_KI_V] : gain_ff[ptt_pkg::REG_KI_H];

   // zero time step and zero gravity act as one lsb
   assign dt_eff   = (item_ff[304:288] == 17'd0) ? 17'd1 : item_ff[304:288];
   assign grav_eff = (gain_ff[ptt_pkg::REG_GRAVITY] == 31'd0) ? 31'd1
                                                              : gain_ff[ptt_pkg::REG_GRAVITY];

   assign pos_diff  = 33'(ref_sel) - 33'(meas_sel);
   assign err_diff  = 33'(err_ff) - 33'(prev_sel);
   assign diff_mag  = err_diff[32] ? 33'(-err_diff) : err_diff;
   assign err_mag   = err_ff[31] ? 32'(-33'(err_ff)) : err_ff;
   assign der_mag   = der_ff[31] ? 32'(-33'(der_ff)) : der_ff;
   assign integ_mag = integ_sel[47] ? 48'(-49'(integ_sel)) : integ_sel;
   assign integ_sum = 49'(integ_sel) + 49'(mul_res);
   assign thrust_base = 33'(acc_ff[2]) + 33'(grav_eff);
   assign thr_mag   = thrust_base[32] ? 32'(-thrust_base) : thrust_base[31:0];

   // shared multiplier operands
   always_comb begin
      mul_start = 1'b0; mul_neg = 1'b0; mul_wide = 1'b0; mul_a = '0; mul_b = '0;
      case (state_ff)
         S_INC_GO: begin
            mul_start = 1'b1; mul_neg = err_ff[31]; mul_wide = 1'b1;
            mul_a = 48'(err_mag); mul_b = 31'(dt_eff);
         end
         S_KP_GO: begin
            mul_start = 1'b1; mul_neg = err_ff[31]; mul_a = 48'(err_mag); mul_b = kp_sel;
         end
         S_KD_GO: begin
            mul_start = 1'b1; mul_neg = der_ff[31]; mul_a = 48'(der_mag); mul_b = kd_sel;
         end
         S_KI_GO: begin
            mul_start = 1'b1; mul_neg = integ_sel[47]; mul_a = integ_mag; mul_b = ki_sel;
         end
         S_TH_GO: begin
            mul_start = 1'b1; mul_neg = thrust_base[32]; mul_a = 48'(thr_mag);
            mul_b = gain_ff[ptt_pkg::REG_MASS];
         end
         default: ;
      endcase
   end

   assign div_start = (state_ff == S_DIV_GO);
   assign cor_start = (state_ff == S_TX_GO) || (state_ff == S_TY_GO);
   assign cor_acc   = (state_ff == S_TY_GO) ? acc_ff[1] : acc_ff[0];

   // sequencer
   always_comb begin
      state_in = state_ff; axis_in = axis_ff; item_in = item_ff;
      err_in = err_ff; der_in = der_ff; sum_in = sum_ff;
      tilt_x_in = tilt_x_ff; tilt_y_in = tilt_y_ff; thrust_in = thrust_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in = req_tdata; axis_in = 2'd0; state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_in   = ptt_pkg::sat34_to32(34'(pos_diff));
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            sum_in   = 34'(ff_sel);
            state_in = S_DIV_W;
         end
         S_DIV_W: if (div_done) begin
            der_in = div_res; state_in = S_INC_GO;
         end
         S_INC_GO: state_in = S_INC_W;
         S_INC_W:  if (mul_done) state_in = S_KP_GO;
         S_KP_GO:  state_in = S_KP_W;
         S_KP_W: if (mul_done) begin
            sum_in = sum_ff + 34'($signed(mul_res[31:0])); state_in = S_KD_GO;
         end
         S_KD_GO:  state_in = S_KD_W;
         S_KD_W: if (mul_done) begin
            sum_in = sum_ff + 34'($signed(mul_res[31:0])); state_in = S_KI_GO;
         end
         S_KI_GO:  state_in = S_KI_W;
         S_KI_W: if (mul_done) begin
            sum_in = sum_ff + 34'($signed(mul_res[31:0])); state_in = S_SUM;
         end
         S_SUM: begin
            if (axis_ff == 2'd2) state_in = S_TX_GO;
            else begin
               axis_in = axis_ff + 2'd1; state_in = S_ERR;
            end
         end
         S_TX_GO: state_in = S_TX_W;
         S_TX_W: if (cor_done) begin
            tilt_x_in = cor_tilt; state_in = S_TY_GO;
         end
         S_TY_GO: state_in = S_TY_W;
         S_TY_W: if (cor_done) begin
            tilt_y_in = cor_tilt; state_in = S_TH_GO;
         end
         S_TH_GO: state_in = S_TH_W;
         S_TH_W: if (mul_done) begin
            thrust_in = mul_res[31:0]; state_in = S_OUT;
         end
         S_OUT: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {4'd0, thrust_ff, acc_ff[2], tilt_y_ff, tilt_x_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) gain_ff[i] <= '0;
         gain_ff[ptt_pkg::REG_GRAVITY] <= ptt_pkg::GRAVITY_RESET;
         gain_ff[ptt_pkg::REG_MASS]    <= ptt_pkg::MASS_RESET;
         for (int i = 0; i < 3; i++) begin
            prev_ff[i]  <= '0;
            integ_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) gain_ff[csr_index] <= csr_data;
         // integral and previous error update once the increment is known
         if (state_ff == S_INC_W && mul_done) begin
            integ_ff[axis_ff] <= ptt_pkg::sat49_to48(integ_sum);
            prev_ff[axis_ff]  <= err_ff;
         end
      end
      axis_ff <= axis_in; item_ff <= item_in;
      err_ff <= err_in; der_ff <= der_in; sum_ff <= sum_in;
      if (state_ff == S_SUM) acc_ff[axis_ff] <= ptt_pkg::sat34_to32(sum_ff);
      tilt_x_ff <= tilt_x_in; tilt_y_ff <= tilt_y_in; thrust_ff <= thrust_in;
      rsp_data_ff <= rsp_data_in;
   end

   ptt_mulq u_mulq (
      .clock(clock), .reset(reset), .start(mul_start), .neg(mul_neg), .a_mag(mul_a),
      .b(mul_b), .wide(mul_wide), .done(mul_done), .result(mul_res)
   );

   ptt_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .neg(err_diff[32]),
      .num_mag(diff_mag), .den(dt_eff), .done(div_done), .result(div_res)
   );

   ptt_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .acc(cor_acc), .grav(grav_eff),
      .done(cor_done), .tilt(cor_tilt)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted item always starts the sequencer
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_ERR)
      else $error("accepted item did not start processing");

   // units are never started together
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && (div_start || cor_start)))
      else $error("two arithmetic units started at once");

   // a waiting result is not overwritten before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result lost");
endmodule
`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for pid_position_to_tilt_thrust: directed and random control ticks,
// predicted in place and compared field by field with every result item
// depends on ptt_pkg and the rtl of pid_position_to_tilt_thrust
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 450;
   localparam int HOLD_CYCLES    = 1500;

   // one control tick as sent on the input channel
   typedef struct {
      logic signed [31:0] ref_pos [3];
      logic signed [31:0] meas_pos [3];
      logic signed [31:0] ff_acc [3];
      logic [16:0]        dt;
   } tick_type;

   // one output item
   typedef struct packed {
      logic signed [31:0] thrust;
      logic signed [31:0] vert_acc;
      logic signed [17:0] tilt_y;
      logic signed [17:0] tilt_x;
   } command_type;

   logic         clock;
   logic         reset;
   logic [311:0] req_tdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [30:0]  csr_data;

   pid_position_to_tilt_thrust u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // controller state as the block should hold it
   logic [30:0] gain_shadow [8];
   longint      last_error [3];
   longint      integ_acc [3];
   command_type command_q [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          rsp_hold;
   bit          no_gaps;

   // atan(2^-i) in q30
   localparam longint ATAN_Q30 [31] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 7, 3, 1, 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor arithmetic ----------------

   function automatic longint clamp_bits(longint v, int bits);
      longint lim;
      lim = (longint'(1) <<< (bits - 1)) - 1;
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // signed value from sign and 128-bit magnitude, clamped
   function automatic longint signed_from_mag(bit neg, logic [127:0] m, int bits);
      logic [127:0] lim;
      lim = (128'd1 << (bits - 1)) - 1;
      if (neg) begin
         if (m > lim + 1) return -longint'(lim[63:0]) - 1;
         return -longint'(m[63:0]);
      end
      if (m > lim) return longint'(lim[63:0]);
      return longint'(m[63:0]);
   endfunction

   // fixed point product, magnitude truncated
   function automatic longint fixed_mul(longint a, logic [63:0] b, int bits);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, b};
      return signed_from_mag(a < 0, p >> ptt_pkg::FRAC_BITS, bits);
   endfunction

   function automatic longint fixed_div(longint num, logic [63:0] d);
      logic [127:0] q;
      q = ({64'd0, magnitude(num)} << ptt_pkg::FRAC_BITS) / {64'd0, d};
      return signed_from_mag(num < 0, q, ptt_pkg::DATA_WIDTH);
   endfunction

   // atan2(acc, g) by vectoring rotations on normalized operands
   function automatic longint tilt_angle(longint acc, logic [63:0] g);
      logic [63:0] ma, mx, zm;
      longint      x, y, z, xs, ys;
      int          s;
      ma = magnitude(acc);
      mx = ma > g ? ma : g;
      s = 0;
      z = 0;
      while (mx < (64'd1 << 52)) begin
         mx = mx << 1;
         s++;
      end
      x = longint'(g << s);
      y = longint'(ma << s);
      if (acc < 0) y = -y;
      for (int i = 0; i < 31; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_Q30[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_Q30[i];
         end
      end
      zm = (magnitude(z) + (64'd1 << 13)) >> 14;
      return z < 0 ? -longint'(zm) : longint'(zm);
   endfunction

   // advances the controller state by one tick and returns the expected command
   function automatic command_type control_tick(tick_type t);
      command_type c;
      logic [63:0] dt, g, kp, kd, ki;
      longint      err, der, inc, acc [3];
      dt = t.dt == 0 ? 64'd1 : 64'(t.dt);
      g  = gain_shadow[ptt_pkg::REG_GRAVITY] == 0 ? 64'd1
                                                  : 64'(gain_shadow[ptt_pkg::REG_GRAVITY]);
      for (int ax = 0; ax < 3; ax++) begin
         kp = ax < 2 ? gain_shadow[ptt_pkg::REG_KP_H] : gain_shadow[ptt_pkg::REG_KP_V];
         kd = ax < 2 ? gain_shadow[ptt_pkg::REG_KD_H] : gain_shadow[ptt_pkg::REG_KD_V];
         ki = ax < 2 ? gain_shadow[ptt_pkg::REG_KI_H] : gain_shadow[ptt_pkg::REG_KI_V];
         err = clamp_bits(longint'(t.ref_pos[ax]) - longint'(t.meas_pos[ax]),
                          ptt_pkg::DATA_WIDTH);
         der = fixed_div(err - last_error[ax], dt);
         inc = fixed_mul(err, dt, ptt_pkg::INTEG_BITS);
         integ_acc[ax] = clamp_bits(integ_acc[ax] + inc, ptt_pkg::INTEG_BITS);
         last_error[ax] = err;
         acc[ax] = clamp_bits(fixed_mul(err, kp, ptt_pkg::DATA_WIDTH)
                   + fixed_mul(der, kd, ptt_pkg::DATA_WIDTH)
                   + fixed_mul(integ_acc[ax], ki, ptt_pkg::DATA_WIDTH)
                   + longint'(t.ff_acc[ax]), ptt_pkg::DATA_WIDTH);
      end
      c.tilt_x   = 18'(tilt_angle(acc[0], g));
      c.tilt_y   = 18'(tilt_angle(acc[1], g));
      c.vert_acc = 32'(acc[2]);
      c.thrust   = 32'(fixed_mul(acc[2] + longint'(g),
                                 64'(gain_shadow[ptt_pkg::REG_MASS]), 32));
      return c;
   endfunction

   // ---------------- channel drivers ----------------

   task automatic send_tick(tick_type t);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      for (int i = 0; i < 3; i++) begin
         req_tdata[32*i +: 32]     <= t.ref_pos[i];
         req_tdata[32*(3+i) +: 32] <= t.meas_pos[i];
         req_tdata[32*(6+i) +: 32] <= t.ff_acc[i];
      end
      req_tdata[304:288] <= t.dt;
      req_tdata[311:305] <= '0;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      command_q.push_back(control_tick(t));
   endtask

   task automatic write_reg(logic [2:0] idx, logic [30:0] value);
      req_tvalid <= 1'b0;
      csr_index  <= idx;
      csr_data   <= value;
      csr_valid  <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gain_shadow[idx] = value;
   endtask

   // all results in, then the block's own latency before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (command_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_all_gains(logic [30:0] kph, kdh, kih, kpv, kdv, kiv, g, m);
      write_reg(ptt_pkg::REG_KP_H, kph);
      write_reg(ptt_pkg::REG_KD_H, kdh);
      write_reg(ptt_pkg::REG_KI_H, kih);
      write_reg(ptt_pkg::REG_KP_V, kpv);
      write_reg(ptt_pkg::REG_KD_V, kdv);
      write_reg(ptt_pkg::REG_KI_V, kiv);
      write_reg(ptt_pkg::REG_GRAVITY, g);
      write_reg(ptt_pkg::REG_MASS, m);
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic logic signed [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'($urandom);
      endcase
   endfunction

   // near-hover tick: small errors and realistic time steps, sometimes raw noise
   function automatic tick_type random_tick(bit noisy);
      tick_type t;
      for (int i = 0; i < 3; i++) begin
         if (noisy) begin
            t.ref_pos[i]  = $urandom_range(0, 3) == 0 ? pick_extreme() : 32'($urandom);
            t.meas_pos[i] = $urandom_range(0, 3) == 0 ? pick_extreme() : 32'($urandom);
            t.ff_acc[i]   = 32'($urandom);
         end else begin
            t.ref_pos[i]  = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            t.meas_pos[i] = t.ref_pos[i] + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            t.ff_acc[i]   = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         end
      end
      if (noisy) t.dt = 17'($urandom);
      else t.dt = 17'($urandom_range(300, 7000));
      return t;
   endfunction

   function automatic logic [30:0] random_gain();
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'h7fff_ffff;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 1 << 19));
      endcase
   endfunction

   // ---------------- tests ----------------

   // registers at their reset values: gains zero, feed-forward straight through
   task automatic test_reset_values();
      tick_type t;
      for (int k = 0; k < 4; k++) begin
         t = random_tick(k[0]);
         send_tick(t);
      end
   endtask

   // field extremes, zero time step, saturation paths
   task automatic test_field_extremes();
      tick_type t;
      wait_idle();
      write_all_gains(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                      31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
      for (int k = 0; k < 14; k++) begin
         for (int i = 0; i < 3; i++) begin
            t.ref_pos[i]  = k[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
            t.meas_pos[i] = k[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            t.ff_acc[i]   = k[1] ? 32'sh7fff_ffff : 32'sh8000_0000;
         end
         if (k >= 8) begin
            t.ref_pos[k % 3] = 32'sd0;
            t.meas_pos[k % 3] = pick_extreme();
         end
         case (k % 4)
            0: t.dt = 17'd0;
            1: t.dt = 17'd1;
            2: t.dt = 17'h1_ffff;
            default: t.dt = 17'd65536;
         endcase
         send_tick(t);
      end
   endtask

   // zero gravity and zero mass, gains at one or zero
   task automatic test_degenerate_gains();
      tick_type t;
      wait_idle();
      write_all_gains(31'd65536, 31'd0, 31'd65536, 31'd65536, 31'd65536, 31'd0, 31'd0, 31'd0);
      for (int k = 0; k < 5; k++) begin
         t = random_tick(k == 4);
         send_tick(t);
      end
      wait_idle();
      write_reg(ptt_pkg::REG_GRAVITY, 31'd1);
      for (int k = 0; k < 2; k++) begin
         t = random_tick(1'b0);
         send_tick(t);
      end
   endtask

   // several random gain settings, mostly well-formed ticks
   task automatic test_random_ticks(int phases, int per_phase);
      tick_type t;
      for (int p = 0; p < phases; p++) begin
         wait_idle();
         write_all_gains(random_gain(), random_gain(), random_gain(), random_gain(),
                         random_gain(), random_gain(),
                         p == 0 ? ptt_pkg::GRAVITY_RESET : random_gain(),
                         p == 0 ? ptt_pkg::MASS_RESET : random_gain());
         no_gaps = (p % 3 == 1);
         for (int k = 0; k < per_phase; k++) begin
            t = random_tick($urandom_range(0, 9) == 0);
            send_tick(t);
         end
         no_gaps = 1'b0;
      end
   endtask

   // receiver holds off so the block fills and stalls its input
   task automatic test_backpressure();
      tick_type t;
      rsp_hold = 1'b1;
      for (int k = 0; k < 6; k++) begin
         t = random_tick(1'b0);
         send_tick(t);
      end
   endtask

   // ---------------- result side ----------------

   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      command_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = command_type'(rsp_tdata[99:0]);
         if (command_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result item, actual %h", $realtime, rsp_tdata);
         end else begin
            want = command_q.pop_front();
            if (got.tilt_x !== want.tilt_x) begin
               error_count++;
               $display("%0t: tilt_x expected %0d actual %0d", $realtime, want.tilt_x, got.tilt_x);
            end
            if (got.tilt_y !== want.tilt_y) begin
               error_count++;
               $display("%0t: tilt_y expected %0d actual %0d", $realtime, want.tilt_y, got.tilt_y);
            end
            if (got.vert_acc !== want.vert_acc) begin
               error_count++;
               $display("%0t: vertical_acc expected %0d actual %0d", $realtime,
                        want.vert_acc, got.vert_acc);
            end
            if (got.thrust !== want.thrust) begin
               error_count++;
               $display("%0t: thrust_force expected %0d actual %0d", $realtime,
                        want.thrust, got.thrust);
            end
            if (rsp_tdata[103:100] !== 4'd0) begin
               error_count++;
               $display("%0t: fill bits expected 0 actual %h", $realtime, rsp_tdata[103:100]);
            end
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      rsp_hold = 1'b0;
      no_gaps = 1'b0;
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= ptt_pkg::REG_KP_H;
      csr_data   <= '0;
      for (int i = 0; i < 3; i++) begin
         last_error[i] = 0;
         integ_acc[i] = 0;
      end
      for (int i = 0; i < 6; i++) gain_shadow[i] = '0;
      gain_shadow[ptt_pkg::REG_GRAVITY] = ptt_pkg::GRAVITY_RESET;
      gain_shadow[ptt_pkg::REG_MASS] = ptt_pkg::MASS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_field_extremes();
      test_degenerate_gains();
      test_random_ticks(4, 165);
      test_backpressure();
      test_random_ticks(1, 20);

      wait_idle();
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
